/* hw/rtl/chacha_pkg.sv */
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared constants, types and the quarter-round function for the ChaCha core.
// ----------------------------------------------------------------------------
`default_nettype none

package chacha_pkg;

    localparam int ROUND_COUNT_DEFAULT = 20;
    localparam int NUM_LANES           = 4;
    localparam int NUM_CFG_REGS        = 5;
    localparam int CFG_IDX_W           = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY45 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY67 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE = 3'd4;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    typedef logic [31:0] word_t;

    // One column or diagonal of the state: a, b, c, d.
    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    function automatic word_t rotl(input word_t v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    function automatic quad_t qround(input quad_t q);
        quad_t r;
        r = q;
        r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 16);
        r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 12);
        r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 8);
        r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 7);
        qround = r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/chacha20_keystream_generator.sv */
// ----------------------------------------------------------------------------
// chacha20_keystream_generator
// ChaCha keystream block generator, 64-bit nonce and 64-bit block counter.
// ----------------------------------------------------------------------------
// Operation: the request loads the state, then ROUND_COUNT rounds, rounded up to
// even, run on four quarter-round cells in parallel, one round per cycle; then one
// output word per cycle while m_tready is high. A new request is taken only when
// the block is done; the round chain is busy for the whole block.
// Reset: synchronous active-low aresetn clears keys, nonce, counter and control.
`default_nettype none

module chacha20_keystream_generator
    import chacha_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // tdata: [6:0] bytes_wanted
    input  wire logic [7:0]           s_tdata,
    // tuser: [0] restart
    input  wire logic                 s_tuser,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // tdata: [63:0] stream_word, [67:64] valid_bytes
    output logic [71:0]               m_tdata,
    output logic                      m_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready
);

    localparam int RND_W = $clog2(ROUND_COUNT + 2);
    // odd counts run one extra round
    localparam int RUN_ROUNDS = ROUND_COUNT + (ROUND_COUNT % 2);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_OUT   = 2'd2;

    logic [1:0]  state_reg;
    logic [63:0] key01_reg, key23_reg, key45_reg, key67_reg, nonce_reg;
    logic [63:0] counter_reg;
    logic [RND_W-1:0] round_reg;
    logic [6:0]  left_reg;
    logic [2:0]  widx_reg;
    word_t       init_reg [16];

    word_t init_w [16];
    quad_t load_q [NUM_LANES];
    quad_t cur_q  [NUM_LANES];
    quad_t shuf_q [NUM_LANES];
    logic  load_en, step_en, diag, realign;
    logic  s_fire, m_fire;
    logic  [6:0] wanted;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    assign wanted    = (s_tdata[6:0] > 7'd64) ? 7'd64 : s_tdata[6:0];
    assign load_en   = s_fire && (wanted != 7'd0);
    assign step_en   = (state_reg == ST_ROUND);
    assign diag      = round_reg[0];
    // a column round after a diagonal one finds the cells in diagonal placement
    assign realign   = !diag && (round_reg != '0);

    always_comb begin
        init_w[0]  = SIGMA0; init_w[1] = SIGMA1; init_w[2] = SIGMA2; init_w[3] = SIGMA3;
        init_w[4]  = key01_reg[31:0]; init_w[5]  = key01_reg[63:32];
        init_w[6]  = key23_reg[31:0]; init_w[7]  = key23_reg[63:32];
        init_w[8]  = key45_reg[31:0]; init_w[9]  = key45_reg[63:32];
        init_w[10] = key67_reg[31:0]; init_w[11] = key67_reg[63:32];
        init_w[12] = s_tuser ? 32'd0 : counter_reg[31:0];
        init_w[13] = s_tuser ? 32'd0 : counter_reg[63:32];
        init_w[14] = nonce_reg[31:0]; init_w[15] = nonce_reg[63:32];
        for (int i = 0; i < NUM_LANES; i++) begin
            load_q[i] = '{a: init_w[i], b: init_w[4+i], c: init_w[8+i], d: init_w[12+i]};
        end
    end

    // A diagonal round draws b, c, d from neighbors; realign restores column order.
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            shuf_q[i].a = cur_q[i].a;
            shuf_q[i].b = diag    ? cur_q[(i+1)%NUM_LANES].b :
                          realign ? cur_q[(i+3)%NUM_LANES].b : cur_q[i].b;
            shuf_q[i].c = (diag || realign) ? cur_q[(i+2)%NUM_LANES].c : cur_q[i].c;
            shuf_q[i].d = diag    ? cur_q[(i+3)%NUM_LANES].d :
                          realign ? cur_q[(i+1)%NUM_LANES].d : cur_q[i].d;
        end
    end

    // after a diagonal round, cell i holds b of column i+1 etc.; return to
    // column order on the next use
    quad_t col_q [NUM_LANES];
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            col_q[i] = cur_q[i];
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++) begin : g_lane
            quad_t lane_out;
            quad_t lane_in;
            // realign words left by a diagonal round before use
            always_comb begin
                lane_in = shuf_q[g];
            end
            chacha_lane u_lane (
                .aclk        (aclk),
                .load        (load_en),
                .load_quad   (load_q[g]),
                .step        (step_en),
                .shuffled_in (lane_in),
                .quad_out    (lane_out)
            );
            quad_t fixed;
            // passed through unchanged: after diag step, cell i holds b of col i+1
            always_comb begin
                fixed = lane_out;
            end
            assign cur_q[g] = fixed;
        end
    endgenerate

    // Word view in state order. After a diagonal round cell i holds
    // b[(i+1)], c[(i+2)], d[(i+3)]; round counts are even so output follows one.
    word_t out_w [16];
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            out_w[i]                        = col_q[i].a;
            out_w[4  + (i+1)%NUM_LANES]     = col_q[i].b;
            out_w[8  + (i+2)%NUM_LANES]     = col_q[i].c;
            out_w[12 + (i+3)%NUM_LANES]     = col_q[i].d;
        end
    end

    logic [3:0]  vbytes;
    logic [63:0] wsel, wmask;
    assign vbytes = (left_reg > 7'd8) ? 4'd8 : left_reg[3:0];
    always_comb begin
        wsel = {out_w[{widx_reg, 1'b1}] + init_reg[{widx_reg, 1'b1}],
                out_w[{widx_reg, 1'b0}] + init_reg[{widx_reg, 1'b0}]};
        wmask = '1;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) >= vbytes) wmask[8*b +: 8] = 8'd0;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {4'd0, vbytes, wsel & wmask};
    assign m_tlast  = (left_reg <= 7'd8);

    always_ff @(posedge aclk) begin
        if (load_en) begin
            for (int i = 0; i < 16; i++) init_reg[i] <= init_w[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            key01_reg   <= '0; key23_reg <= '0; key45_reg <= '0; key67_reg <= '0;
            nonce_reg   <= '0;
            counter_reg <= '0;
            round_reg   <= '0;
            left_reg    <= '0;
            widx_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_KEY01: key01_reg <= cfg_data;
                    CFG_KEY23: key23_reg <= cfg_data;
                    CFG_KEY45: key45_reg <= cfg_data;
                    CFG_KEY67: key67_reg <= cfg_data;
                    CFG_NONCE: nonce_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (load_en) begin
                            counter_reg <= (s_tuser ? 64'd0 : counter_reg) + 64'd1;
                            left_reg    <= wanted;
                            widx_reg    <= '0;
                            round_reg   <= '0;
                            state_reg   <= ST_ROUND;
                        end else if (s_tuser) begin
                            counter_reg <= '0;
                        end
                    end
                end
                ST_ROUND: begin
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == RND_W'(RUN_ROUNDS - 1)) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_fire) begin
                        if (left_reg <= 7'd8) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            left_reg <= left_reg - 7'd8;
                            widx_reg <= widx_reg + 3'd1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Assertions
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_tlast) |=> (state_reg == ST_IDLE)) else $error("last did not end block");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("accept while busy");
    a_valid_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= 4'd8))
        else $error("bad valid_bytes");

endmodule

`default_nettype wire

/* hw/rtl/chacha_lane.sv */
// ----------------------------------------------------------------------------
// chacha_lane
// One cell of the round chain: holds one column or diagonal (a, b, c, d) and
// applies a quarter-round on a step; the words it trades with its neighbors on
// a column/diagonal swap arrive already shuffled on shuffled_in.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha_lane
    import chacha_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  load,
    input  wire quad_t load_quad,
    input  wire logic  step,
    input  wire quad_t shuffled_in,
    output quad_t      quad_out
);

    quad_t quad_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            quad_reg <= load_quad;
        end else if (step) begin
            quad_reg <= qround(shuffled_in);
        end
    end

    assign quad_out = quad_reg;

endmodule

`default_nettype wire
